// ===== sv/dedup_fifo_queue_top_macros.svh =====
// Assertion macros used by the top-level file to check this block.
`ifndef DEDUP_FIFO_QUEUE_TOP_MACROS_SVH
`define DEDUP_FIFO_QUEUE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DFQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define DFQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define DFQ_ASSERT(label, prop, msg)
`define DFQ_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== sv/dfq_pkg.sv =====
package dfq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 3;

    localparam int CQ_DEPTH    = 2;
    localparam int CQ_PTR_W    = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
    localparam int CQ_CNT_W    = $clog2(CQ_DEPTH + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [OCC_W-1:0] occ_t;
    typedef logic [ID_W-1:0]  id_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 3'd0,
        CMD_DEQUEUE = 3'd1,
        CMD_LIST    = 3'd2,
        CMD_DRAIN   = 3'd3,
        CMD_CLOSE   = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_ENTRY     = 3'd4,
        ST_CLOSED_W  = 3'd5,
        ST_CLOSED_E  = 3'd6
    } status_t;

    typedef struct packed {
        cmd_t cmd;
        id_t  ident;
    } item_t;

    typedef struct packed {
        occ_t occupancy;
        logic busy;
    } back_stat_t;

endpackage

// ===== sv/dfq_front.sv =====
module dfq_front import dfq_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CMD_W-1:0]  s_cmd,
    input  logic [ID_W-1:0]   s_ident,
    output logic              q_push,
    output item_t             q_item,
    input  logic              q_ready
);

    logic  fv_reg, fv_next;
    item_t item_reg, item_next;
    logic  known;

    assign s_ready = !fv_reg || q_ready;
    assign q_push  = fv_reg;
    assign q_item  = item_reg;

    always_comb begin
        case (cmd_t'(s_cmd))
            CMD_ENQUEUE, CMD_DEQUEUE, CMD_LIST, CMD_DRAIN, CMD_CLOSE: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    // Unused command codes are taken and dropped here; they cause no result.
    always_comb begin
        fv_next   = fv_reg;
        item_next = item_reg;
        if (q_ready) begin
            fv_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            fv_next         = known;
            item_next.cmd   = cmd_t'(s_cmd);
            item_next.ident = s_ident;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else begin
            fv_reg <= fv_next;
        end
        item_reg <= item_next;
    end

endmodule

// ===== sv/dfq_cmd_queue.sv =====
module dfq_cmd_queue import dfq_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  push_ready,
    input  logic  pop,
    output item_t pop_item,
    output logic  pop_valid
);

    item_t                entries [CQ_DEPTH];
    logic [CQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0]  count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    function automatic logic [CQ_PTR_W-1:0] ptr_inc(logic [CQ_PTR_W-1:0] p);
        if (p == CQ_PTR_W'(CQ_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign push_ready = (count_reg != CQ_CNT_W'(CQ_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entries[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/dfq_back.sv =====
module dfq_back import dfq_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  item_t               q_item,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [ID_W-1:0]     m_ident_out,
    output logic                m_last,
    output back_stat_t          stat
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_EMIT  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    idx_t                   head_reg, head_next;
    occ_t                   occ_reg, occ_next;
    idx_t                   cnt_reg, cnt_next;
    logic                   drain_reg, drain_next;
    id_t                    id_reg, id_next;
    logic [QUEUE_DEPTH-1:0] match_reg, match_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    id_t                    out_ident_reg, out_ident_next;
    logic                   out_last_reg, out_last_next;

    id_t                    slots [QUEUE_DEPTH];
    logic                   wr_en;
    idx_t                   wr_idx;
    idx_t                   rd_idx;
    id_t                    rd_data;
    logic [QUEUE_DEPTH-1:0] occ_mask;
    logic [QUEUE_DEPTH-1:0] match_now;
    logic                   out_free;
    logic                   emit_last;

    function automatic idx_t idx_add(idx_t a, idx_t b);
        logic [IDX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (IDX_W + 1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic idx_t idx_sub(idx_t a, idx_t b);
        logic [IDX_W:0] diff;
        diff = {1'b0, a} + (IDX_W + 1)'(QUEUE_DEPTH) - {1'b0, b};
        if (diff >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
            diff = diff - (IDX_W + 1)'(QUEUE_DEPTH);
        end
        return diff[IDX_W-1:0];
    endfunction

    // An entry takes part in the duplicate check only when it lies inside the ring window.
    always_comb begin
        idx_t off;
        off = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            off          = idx_sub(IDX_W'(i), head_reg);
            occ_mask[i]  = (OCC_W'(off) < occ_reg);
            match_now[i] = occ_mask[i] && (slots[i] == q_item.ident);
        end
    end

    assign out_free  = !out_valid_reg || m_ready;
    assign rd_idx    = idx_add(head_reg, cnt_reg);
    assign rd_data   = slots[rd_idx];
    assign wr_idx    = idx_add(head_reg, occ_reg[IDX_W-1:0]);
    assign emit_last = ((OCC_W'(cnt_reg) + 1'b1) == occ_reg);

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        occ_next        = occ_reg;
        cnt_next        = cnt_reg;
        drain_next      = drain_reg;
        id_next         = id_reg;
        match_next      = match_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_ident_next  = out_ident_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        wr_en           = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    case (q_item.cmd)
                        CMD_ENQUEUE: begin
                            q_pop      = 1'b1;
                            id_next    = q_item.ident;
                            match_next = match_now;
                            state_next = S_CHECK;
                        end
                        CMD_DEQUEUE: begin
                            if (out_free) begin
                                q_pop          = 1'b1;
                                out_valid_next = 1'b1;
                                out_last_next  = 1'b1;
                                if (occ_reg == '0) begin
                                    out_status_next = ST_EMPTY;
                                    out_ident_next  = '0;
                                end else begin
                                    out_status_next = ST_ENTRY;
                                    out_ident_next  = rd_data;
                                    head_next       = idx_add(head_reg, idx_t'(1));
                                    occ_next        = occ_reg - 1'b1;
                                end
                            end
                        end
                        CMD_LIST, CMD_DRAIN: begin
                            if (out_free) begin
                                q_pop = 1'b1;
                                if (occ_reg == '0) begin
                                    out_valid_next  = 1'b1;
                                    out_last_next   = 1'b1;
                                    out_status_next = ST_EMPTY;
                                    out_ident_next  = '0;
                                end else begin
                                    drain_next = (q_item.cmd == CMD_DRAIN);
                                    state_next = S_EMIT;
                                end
                            end
                        end
                        CMD_CLOSE: begin
                            if (out_free) begin
                                q_pop           = 1'b1;
                                out_valid_next  = 1'b1;
                                out_last_next   = 1'b1;
                                out_ident_next  = '0;
                                out_status_next = (occ_reg != '0) ? ST_CLOSED_W : ST_CLOSED_E;
                                head_next       = '0;
                                occ_next        = '0;
                            end
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_ident_next = '0;
                    state_next     = S_IDLE;
                    if (|match_reg) begin
                        out_status_next = ST_DUPLICATE;
                    end else if (occ_reg == OCC_W'(QUEUE_DEPTH)) begin
                        out_status_next = ST_FULL;
                    end else begin
                        out_status_next = ST_ACCEPTED;
                        wr_en           = 1'b1;
                        occ_next        = occ_reg + 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_ENTRY;
                    out_ident_next  = rd_data;
                    out_last_next   = emit_last;
                    cnt_next        = cnt_reg + 1'b1;
                    if (emit_last) begin
                        cnt_next   = '0;
                        state_next = S_IDLE;
                        if (drain_reg) begin
                            head_next = '0;
                            occ_next  = '0;
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            cnt_reg       <= cnt_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
        id_reg         <= id_next;
        match_reg      <= match_next;
        out_status_reg <= out_status_next;
        out_ident_reg  <= out_ident_next;
        out_last_reg   <= out_last_next;
        if (wr_en) begin
            slots[wr_idx] <= id_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_status_reg;
    assign m_ident_out    = out_ident_reg;
    assign m_last         = out_last_reg;
    assign stat.occupancy = occ_reg;
    assign stat.busy      = (state_reg != S_IDLE);

endmodule

// ===== sv/dedup_fifo_queue_top.sv =====
// A first-in first-out queue of up to QUEUE_DEPTH unique 16-bit identifiers driven by
// commands (enqueue, dequeue, list, drain, close). A front stage registers and decodes
// each transaction and drops unused command codes; a two-entry command queue feeds the
// back end, which owns the ring storage and a registered result port. In the back end an
// enqueue takes two steps (a registered compare against every occupied entry, then the
// decision and write), a dequeue or close takes one step, and a list or drain takes one
// step to start, then streams one queued entry per cycle while the result side is
// ready, so the rate is set by the back end and by how fast the result side takes
// transactions. A result is registered after the front register and the command queue.
`include "dedup_fifo_queue_top_macros.svh"

module dedup_fifo_queue_top import dfq_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [ID_W-1:0]     s_ident,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [ID_W-1:0]     m_ident_out,
    output logic                m_last
);

    logic       f_push;
    item_t      f_item;
    logic       f_ready;
    logic       q_valid;
    item_t      q_item;
    logic       q_pop;
    back_stat_t stat;

    dfq_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .s_ident (s_ident),
        .q_push  (f_push),
        .q_item  (f_item),
        .q_ready (f_ready)
    );

    dfq_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (f_push),
        .push_item  (f_item),
        .push_ready (f_ready),
        .pop        (q_pop),
        .pop_item   (q_item),
        .pop_valid  (q_valid)
    );

    dfq_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_ident_out (m_ident_out),
        .m_last      (m_last),
        .stat        (stat)
    );

    `DFQ_ASSERT(a_occ_bound, stat.occupancy <= OCC_W'(QUEUE_DEPTH), "occupancy beyond depth")
    `DFQ_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_valid, "result valid after reset")
    `DFQ_ASSERT(a_single_result, (m_valid && m_status != ST_ENTRY) |-> (m_last && m_ident_out == '0), "status result must be final and carry no identifier")
    `DFQ_ASSERT(a_pop_valid, q_pop |-> q_valid, "command popped from empty queue")
    `DFQ_ASSERT(a_busy_no_pop, stat.busy |-> !q_pop, "command popped while back end busy")

endmodule
